// ----- sv/bpd_pkg.sv -----
`timescale 1ns / 1ps

package bpd_pkg;

	// field limits
	localparam int MAX_FIELD_BITS = 32;
	localparam int POSITION_WIDTH = 32;

	// delta code layout
	localparam int SHORT_DELTA_BITS = 7;
	localparam int LONG_BASE        = 8;
	localparam int LEN_CODE_BITS    = 4;
	localparam int LONG_EXTRA_MAX   = 15;
	localparam int MAX_DELTA_BITS   = SHORT_DELTA_BITS + LONG_EXTRA_MAX;

	// elements one item can produce
	localparam int MAX_ELEMS = 4;

	// action codes
	localparam logic [1:0] ACT_BITS  = 2'd0;
	localparam logic [1:0] ACT_POS   = 2'd1;
	localparam logic [1:0] ACT_FLUSH = 2'd2;

	// element kinds
	localparam logic [1:0] KIND_BITS = 2'd0;
	localparam logic [1:0] KIND_MARK = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] bits_value;
		logic [5:0]  bit_count;
		logic [31:0] position;
		logic        prev_valid;
		logic [31:0] prev_position;
	} item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  bits;
		logic [3:0]  count;
		logic [31:0] pos;
	} elem_t;

	// all elements of one item, handed from the packer to the output queue
	typedef struct packed {
		logic [2:0]                  cnt;
		elem_t [MAX_ELEMS-1:0]       elem;
	} burst_t;

endpackage

// ----- sv/bpd_if.sv -----
`timescale 1ns / 1ps

// input item channel
interface bpd_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [31:0] bits_value;
	logic [5:0]  bit_count;
	logic [31:0] position;
	logic        prev_valid;
	logic [31:0] prev_position;

	modport source (
		output valid, action, bits_value, bit_count, position, prev_valid, prev_position,
		input  ready
	);
	modport sink (
		input  valid, action, bits_value, bit_count, position, prev_valid, prev_position,
		output ready
	);
endinterface

// result element channel
interface bpd_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  element_kind;
	logic [7:0]  element_bits;
	logic [3:0]  element_count;
	logic [31:0] marker_position;
	logic        last_of_run;

	modport source (
		output valid, element_kind, element_bits, element_count, marker_position,
		       last_of_run,
		input  ready
	);
	modport sink (
		input  valid, element_kind, element_bits, element_count, marker_position,
		       last_of_run,
		output ready
	);
endinterface

// ----- sv/bpd_packer.sv -----
`timescale 1ns / 1ps

module bpd_packer import bpd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  item_t  in_item,
	input  logic   load_ok,
	output logic   load,
	output burst_t burst
);

	logic        valid_s1;
	item_t       item_s1;
	logic [7:0]  partial_q;
	logic [2:0]  used_q;

	logic        advance;
	logic [7:0]  partial_d;
	logic [2:0]  used_d;

	// field to append
	logic        do_pack;
	logic [31:0] fv;
	logic [5:0]  fn;

	// delta decode
	logic [POSITION_WIDTH-1:0] delta;
	logic [31:0] dmag;
	logic        bad_delta;
	logic        short_delta;
	logic [4:0]  dlen;

	// packing window
	logic [31:0] fmask;
	logic [39:0] win;
	logic [39:0] win_rest;
	logic [5:0]  shamt;
	logic [5:0]  total;
	logic [2:0]  nbytes;

	// input register
	assign advance  = valid_s1 && ((burst.cnt == 3'd0) || load_ok);
	assign in_ready = !valid_s1 || advance;
	assign load     = advance && (burst.cnt != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	// delta and its code length
	always_comb begin
		delta       = item_s1.position[POSITION_WIDTH-1:0]
		            - item_s1.prev_position[POSITION_WIDTH-1:0];
		dmag        = 32'(delta[POSITION_WIDTH-2:0]);
		bad_delta   = (delta == '0) || delta[POSITION_WIDTH-1] ||
		              (|dmag[31:MAX_DELTA_BITS]);
		short_delta = (dmag[31:SHORT_DELTA_BITS] == '0);
		dlen        = 5'(LONG_BASE);
		for (int i = SHORT_DELTA_BITS; i < MAX_DELTA_BITS; i++) begin
			if (dmag[i]) dlen = 5'(i + 1);
		end
	end

	// pick the field to append
	always_comb begin
		do_pack = 1'b0;
		fv      = '0;
		fn      = '0;
		case (item_s1.action)
			ACT_BITS: begin
				do_pack = 1'b1;
				fv      = item_s1.bits_value;
				fn      = (item_s1.bit_count > 6'(MAX_FIELD_BITS)) ?
				          6'(MAX_FIELD_BITS) : item_s1.bit_count;
			end
			ACT_POS: begin
				if (item_s1.prev_valid && !bad_delta) begin
					do_pack = 1'b1;
					if (short_delta) begin
						fv = {24'b0, 1'b0, dmag[SHORT_DELTA_BITS-1:0]};
						fn = 6'(SHORT_DELTA_BITS + 1);
					end else begin
						fv = (32'd1 << (dlen + 5'(LEN_CODE_BITS)))
						   | (32'(dlen - 5'(LONG_BASE)) << dlen)
						   | dmag;
						fn = 6'(dlen) + 6'(LEN_CODE_BITS + 1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	// MSB-aligned window: pending bits then the new field
	always_comb begin
		fmask    = 32'((64'd1 << fn) - 64'd1);
		total    = 6'(used_q) + fn;
		shamt    = 6'd40 - total;
		win      = {partial_q, 32'b0} | (({8'b0, fv & fmask}) << shamt);
		nbytes   = total[5:3];
		win_rest = win << {nbytes, 3'b0};
	end

	// element list and next state
	always_comb begin
		burst     = '0;
		partial_d = partial_q;
		used_d    = used_q;
		if (do_pack) begin
			burst.cnt = nbytes;
			for (int i = 0; i < MAX_ELEMS; i++) begin
				if (3'(i) < nbytes) begin
					burst.elem[i].kind  = KIND_BITS;
					burst.elem[i].bits  = win[39-8*i -: 8];
					burst.elem[i].count = 4'd8;
				end
			end
			partial_d = win_rest[39:32];
			used_d    = total[2:0];
		end else begin
			case (item_s1.action)
				ACT_POS: begin
					if (item_s1.prev_valid) begin
						// bad delta: error only, state kept
						burst.elem[0].kind = KIND_ERR;
						burst.cnt          = 3'd1;
					end else begin
						if (used_q != 3'd0) begin
							burst.elem[0].kind  = KIND_BITS;
							burst.elem[0].bits  = partial_q;
							burst.elem[0].count = {1'b0, used_q};
							burst.elem[1].kind  = KIND_MARK;
							burst.elem[1].pos   =
								32'(item_s1.position[POSITION_WIDTH-1:0]);
							burst.cnt           = 3'd2;
						end else begin
							burst.elem[0].kind = KIND_MARK;
							burst.elem[0].pos  =
								32'(item_s1.position[POSITION_WIDTH-1:0]);
							burst.cnt          = 3'd1;
						end
						partial_d = '0;
						used_d    = '0;
					end
				end
				ACT_FLUSH: begin
					if (used_q != 3'd0) begin
						burst.elem[0].kind  = KIND_BITS;
						burst.elem[0].bits  = partial_q;
						burst.elem[0].count = {1'b0, used_q};
						burst.cnt           = 3'd1;
					end
					partial_d = '0;
					used_d    = '0;
				end
				default: begin
				end
			endcase
		end
	end

	// partial byte state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			used_q    <= '0;
		end else if (advance) begin
			partial_q <= partial_d;
			used_q    <= used_d;
		end
	end

endmodule

// ----- sv/bpd_outq.sv -----
`timescale 1ns / 1ps

module bpd_outq import bpd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   load,
	input  burst_t burst,
	output logic   load_ok,
	output logic   out_valid,
	input  logic   out_ready,
	output elem_t  out_elem,
	output logic   out_last
);

	elem_t [MAX_ELEMS-1:0] q_q;
	logic [2:0]            cnt_q;
	logic                  take;

	assign out_valid = (cnt_q != 3'd0);
	assign take      = out_valid && out_ready;
	assign load_ok   = (cnt_q == 3'd0) || ((cnt_q == 3'd1) && take);
	assign out_elem  = q_q[0];
	assign out_last  = (cnt_q == 3'd1);

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= burst.cnt;
		end else if (take) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	// element slots, head at slot 0
	always_ff @(posedge clk) begin
		if (load) begin
			q_q <= burst.elem;
		end else if (take) begin
			for (int i = 0; i < MAX_ELEMS - 1; i++) begin
				q_q[i] <= q_q[i+1];
			end
			q_q[MAX_ELEMS-1] <= '0;
		end
	end

endmodule

// ----- sv/bit_packer_with_delta_positions.sv -----
`timescale 1ns / 1ps
// An item is held in the input register, then its results load into the output queue.
// Throughput: one result beat per cycle while the output is ready; an item's results
// (at most four) wait in the output queue, which holds one item's beats.
// Items with one or no result are taken every cycle while the output is ready.
// Reset (arst_n low): partial byte and bit count cleared, pipeline and queue emptied.

module bit_packer_with_delta_positions import bpd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	bpd_in_if.sink    items,
	bpd_out_if.source elements
);

	item_t  in_item;
	burst_t burst;
	logic   load;
	logic   load_ok;
	elem_t  out_elem;
	logic   out_last;

	assign in_item.action        = items.action;
	assign in_item.bits_value    = items.bits_value;
	assign in_item.bit_count     = items.bit_count;
	assign in_item.position      = items.position;
	assign in_item.prev_valid    = items.prev_valid;
	assign in_item.prev_position = items.prev_position;

	bpd_packer u_packer (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (items.valid),
		.in_ready (items.ready),
		.in_item  (in_item),
		.load_ok  (load_ok),
		.load     (load),
		.burst    (burst)
	);

	bpd_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.burst     (burst),
		.load_ok   (load_ok),
		.out_valid (elements.valid),
		.out_ready (elements.ready),
		.out_elem  (out_elem),
		.out_last  (out_last)
	);

	assign elements.element_kind    = out_elem.kind;
	assign elements.element_bits    = out_elem.bits;
	assign elements.element_count   = out_elem.count;
	assign elements.marker_position = out_elem.pos;
	assign elements.last_of_run     = out_last;

endmodule
